// File: sv/ap_rhs_pkg.sv
package ap_rhs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 24;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int NUM_WIDTH  = DATA_WIDTH + FRAC_BITS;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (NUM_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

  localparam cfg_idx_t REG_GAIN_K   = 3'd0;
  localparam cfg_idx_t REG_THRESH_A = 3'd1;
  localparam cfg_idx_t REG_MU1      = 3'd2;
  localparam cfg_idx_t REG_MU2      = 3'd3;
  localparam cfg_idx_t REG_EPS0     = 3'd4;
  localparam cfg_idx_t REG_USE_A    = 3'd5;
  localparam cfg_idx_t REG_USE_K    = 3'd6;

  localparam data_t VMAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam data_t VMIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});
  localparam data_t ONE_VAL = (FRAC_BITS < DATA_WIDTH - 1) ?
                              data_t'(64'(1) << FRAC_BITS) : VMAX;

  typedef struct packed {
    logic  sat;
    data_t val;
  } sres_t;

  function automatic sres_t sat_add(data_t a, data_t b);
    logic signed [DATA_WIDTH:0] s;
    sres_t res;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    res.sat = s[DATA_WIDTH] != s[DATA_WIDTH-1];
    res.val = res.sat ? (s[DATA_WIDTH] ? VMIN : VMAX) : data_t'(s);
    return res;
  endfunction

  function automatic sres_t sat_sub(data_t a, data_t b);
    logic signed [DATA_WIDTH:0] s;
    sres_t res;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    res.sat = s[DATA_WIDTH] != s[DATA_WIDTH-1];
    res.val = res.sat ? (s[DATA_WIDTH] ? VMIN : VMAX) : data_t'(s);
    return res;
  endfunction

  // Round magnitude to nearest (ties away from zero), then clip.
  function automatic sres_t fx_round(prod_t p);
    logic neg;
    logic [PROD_WIDTH-1:0] m;
    logic [PROD_WIDTH-1:0] r;
    logic [PROD_WIDTH-1:0] lim;
    sres_t res;
    neg = p[PROD_WIDTH-1];
    m   = neg ? (~p + 1'b1) : p;
    r   = (m + (PROD_WIDTH'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = PROD_WIDTH'(VMAX) + PROD_WIDTH'(neg);
    res.sat = r > lim;
    if (res.sat) begin
      res.val = neg ? VMIN : VMAX;
    end else begin
      res.val = neg ? data_t'(~r + 1'b1) : data_t'(r);
    end
    return res;
  endfunction

  function automatic sres_t clip_quot(logic [NUM_WIDTH-1:0] q, logic neg);
    logic [NUM_WIDTH-1:0] lim;
    sres_t res;
    lim = NUM_WIDTH'(VMAX) + NUM_WIDTH'(neg);
    res.sat = q > lim;
    if (res.sat) begin
      res.val = neg ? VMIN : VMAX;
    end else begin
      res.val = neg ? data_t'(~q + 1'b1) : data_t'(q);
    end
    return res;
  endfunction

endpackage

// File: sv/ap_rhs_in_if.sv
interface ap_rhs_in_if;
  logic                valid;
  logic                ready;
  ap_rhs_pkg::data_t   potential_u;
  ap_rhs_pkg::data_t   recovery_v;
  ap_rhs_pkg::data_t   point_a;
  ap_rhs_pkg::data_t   point_k;

  modport source (output valid, potential_u, recovery_v, point_a, point_k, input ready);
  modport sink (input valid, potential_u, recovery_v, point_a, point_k, output ready);
endinterface

// File: sv/ap_rhs_out_if.sv
interface ap_rhs_out_if;
  logic                valid;
  logic                ready;
  ap_rhs_pkg::data_t   rate_u;
  ap_rhs_pkg::data_t   rate_v;
  logic                divide_fault;
  logic                saturated;

  modport source (output valid, rate_u, rate_v, divide_fault, saturated, input ready);
  modport sink (input valid, rate_u, rate_v, divide_fault, saturated, output ready);
endinterface

// File: sv/aliev_panfilov_reaction_rhs_top.sv
// Aliev-Panfilov reaction terms for one mesh point per transfer.
// in_ch carries potential u, recovery v and per-point a and k (signed fixed
// point); out_ch returns rate_u = f, rate_v = g, divide_fault and saturated.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 gain k,
// 1 threshold a, 2 mu1, 3 mu2, 4 eps0, 5 use point a, 6 use point k);
// write only while no transfer is in flight. Unknown indexes are dropped.
// The v/(mu2+u) quotient is the long path from input transfer to result
// valid, resolved two quotient bits per stage, and f and the right factor
// of g wait for it in a delay line.
// Throughput: one point per cycle. Every stage advances together; when the
// receiver holds out_ch.ready low with a result waiting, the whole pipe
// and in_ch.ready hold, and nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits and the
// configuration registers to zero; results in flight are dropped.
module aliev_panfilov_reaction_rhs_top (
  input  logic                         clk,
  input  logic                         rst_n,
  ap_rhs_in_if.sink                    in_ch,
  ap_rhs_out_if.source                 out_ch,
  input  logic                         cfg_we,
  input  ap_rhs_pkg::cfg_idx_t         cfg_index,
  input  ap_rhs_pkg::data_t            cfg_data
);

  localparam int DW      = ap_rhs_pkg::DATA_WIDTH;
  localparam int NW      = ap_rhs_pkg::NUM_WIDTH;
  localparam int DS      = ap_rhs_pkg::DIV_STAGES;
  localparam int NSTAGE  = DS + 7;
  // Delay line runs from the stage that finishes f to the stage that forms e.
  localparam int SIDE_LAST = DS - 4;

  typedef ap_rhs_pkg::data_t data_t;
  typedef ap_rhs_pkg::prod_t prod_t;
  typedef ap_rhs_pkg::sres_t sres_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [NW-1:0] nq;     // numerator bits shift out, quotient bits shift in
    logic [DW-1:0] md;
    logic          neg;
    logic          zero;
    logic          vpos;
    logic          vneg;
  } dv_t;

  typedef struct packed {
    logic  sat;
    data_t f;
    data_t w;
  } side_t;

  // Configuration registers
  data_t gain_k_r, thresh_a_r, mu1_r, mu2_r, eps0_r;
  logic  use_a_r, use_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_k_r   <= '0;
      thresh_a_r <= '0;
      mu1_r      <= '0;
      mu2_r      <= '0;
      eps0_r     <= '0;
      use_a_r    <= 1'b0;
      use_k_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ap_rhs_pkg::REG_GAIN_K:   gain_k_r   <= cfg_data;
        ap_rhs_pkg::REG_THRESH_A: thresh_a_r <= cfg_data;
        ap_rhs_pkg::REG_MU1:      mu1_r      <= cfg_data;
        ap_rhs_pkg::REG_MU2:      mu2_r      <= cfg_data;
        ap_rhs_pkg::REG_EPS0:     eps0_r     <= cfg_data;
        ap_rhs_pkg::REG_USE_A:    use_a_r    <= cfg_data[0];
        ap_rhs_pkg::REG_USE_K:    use_k_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while a finished result is refused.
  logic en;
  logic [1:NSTAGE] vld_r;

  assign en          = !(vld_r[NSTAGE] && !out_ch.ready);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {in_ch.valid, vld_r[1:NSTAGE-1]};
    end
  end

  // Stage 1: select a and k, first differences, divisor.
  data_t a_sel, k_sel;
  sres_t ua_c, um1_c, d_c;
  assign a_sel = use_a_r ? in_ch.point_a : thresh_a_r;
  assign k_sel = use_k_r ? in_ch.point_k : gain_k_r;
  assign ua_c  = ap_rhs_pkg::sat_sub(in_ch.potential_u, a_sel);
  assign um1_c = ap_rhs_pkg::sat_sub(in_ch.potential_u, ap_rhs_pkg::ONE_VAL);
  assign d_c   = ap_rhs_pkg::sat_add(mu2_r, in_ch.potential_u);

  data_t s1_u_r, s1_v_r, s1_k_r, s1_ua_r, s1_um1_r, s1_d_r;
  logic  s1_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_u_r   <= in_ch.potential_u;
      s1_v_r   <= in_ch.recovery_v;
      s1_k_r   <= k_sel;
      s1_ua_r  <= ua_c.val;
      s1_um1_r <= um1_c.val;
      s1_d_r   <= d_c.val;
      s1_sat_r <= ua_c.sat | um1_c.sat | d_c.sat;
    end
  end

  // Stage 2: first products, w0 = (u-a)-1, divider setup.
  sres_t w0_c;
  dv_t   dv_init;
  assign w0_c = ap_rhs_pkg::sat_sub(s1_ua_r, ap_rhs_pkg::ONE_VAL);

  always_comb begin
    logic [DW-1:0] mv, md;
    mv = s1_v_r[DW-1] ? (~s1_v_r + 1'b1) : s1_v_r;
    md = s1_d_r[DW-1] ? (~s1_d_r + 1'b1) : s1_d_r;
    dv_init.rem  = '0;
    dv_init.nq   = {mv, {ap_rhs_pkg::FRAC_BITS{1'b0}}};
    dv_init.md   = md;
    dv_init.neg  = s1_v_r[DW-1] ^ s1_d_r[DW-1];
    dv_init.zero = (s1_d_r == '0);
    dv_init.vpos = !s1_v_r[DW-1] && (s1_v_r != '0);
    dv_init.vneg = s1_v_r[DW-1];
  end

  prod_t s2_puua_r, s2_puv_r;
  data_t s2_u_r, s2_v_r, s2_k_r, s2_um1_r, s2_w0_r;
  logic  s2_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_puua_r <= s1_u_r * s1_ua_r;
      s2_puv_r  <= s1_u_r * s1_v_r;
      s2_u_r    <= s1_u_r;
      s2_v_r    <= s1_v_r;
      s2_k_r    <= s1_k_r;
      s2_um1_r  <= s1_um1_r;
      s2_w0_r   <= w0_c.val;
      s2_sat_r  <= s1_sat_r | w0_c.sat;
    end
  end

  // Stage 3
  sres_t t1_c, uvr_c;
  assign t1_c  = ap_rhs_pkg::fx_round(s2_puua_r);
  assign uvr_c = ap_rhs_pkg::fx_round(s2_puv_r);

  prod_t s3_pkw_r;
  data_t s3_t1_r, s3_uvr_r, s3_u_r, s3_v_r, s3_k_r, s3_um1_r;
  logic  s3_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_pkw_r <= s2_k_r * s2_w0_r;
      s3_t1_r  <= t1_c.val;
      s3_uvr_r <= uvr_c.val;
      s3_u_r   <= s2_u_r;
      s3_v_r   <= s2_v_r;
      s3_k_r   <= s2_k_r;
      s3_um1_r <= s2_um1_r;
      s3_sat_r <= s2_sat_r | t1_c.sat | uvr_c.sat;
    end
  end

  // Stage 4
  sres_t wk_c;
  assign wk_c = ap_rhs_pkg::fx_round(s3_pkw_r);

  prod_t s4_pt_r;
  data_t s4_wk_r, s4_uvr_r, s4_u_r, s4_v_r, s4_k_r;
  logic  s4_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_pt_r  <= s3_t1_r * s3_um1_r;
      s4_wk_r  <= wk_c.val;
      s4_uvr_r <= s3_uvr_r;
      s4_u_r   <= s3_u_r;
      s4_v_r   <= s3_v_r;
      s4_k_r   <= s3_k_r;
      s4_sat_r <= s3_sat_r | wk_c.sat;
    end
  end

  // Stage 5
  sres_t t2_c;
  assign t2_c = ap_rhs_pkg::fx_round(s4_pt_r);

  prod_t s5_puw_r;
  data_t s5_t2_r, s5_uvr_r, s5_v_r, s5_k_r;
  logic  s5_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_puw_r <= s4_u_r * s4_wk_r;
      s5_t2_r  <= t2_c.val;
      s5_uvr_r <= s4_uvr_r;
      s5_v_r   <= s4_v_r;
      s5_k_r   <= s4_k_r;
      s5_sat_r <= s4_sat_r | t2_c.sat;
    end
  end

  // Stage 6
  sres_t wu_c;
  assign wu_c = ap_rhs_pkg::fx_round(s5_puw_r);

  prod_t s6_pkt_r;
  data_t s6_wu_r, s6_uvr_r, s6_v_r;
  logic  s6_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_pkt_r <= s5_k_r * s5_t2_r;
      s6_wu_r  <= wu_c.val;
      s6_uvr_r <= s5_uvr_r;
      s6_v_r   <= s5_v_r;
      s6_sat_r <= s5_sat_r | wu_c.sat;
    end
  end

  // Stage 7
  sres_t t3_c, wv_c;
  assign t3_c = ap_rhs_pkg::fx_round(s6_pkt_r);
  assign wv_c = ap_rhs_pkg::sat_add(s6_wu_r, s6_v_r);

  data_t s7_t3_r, s7_wv_r, s7_uvr_r;
  logic  s7_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_t3_r  <= t3_c.val;
      s7_wv_r  <= wv_c.val;
      s7_uvr_r <= s6_uvr_r;
      s7_sat_r <= s6_sat_r | t3_c.sat | wv_c.sat;
    end
  end

  // Stage 8: negate both.
  sres_t nt_c, wn_c;
  assign nt_c = ap_rhs_pkg::sat_sub(data_t'(0), s7_t3_r);
  assign wn_c = ap_rhs_pkg::sat_sub(data_t'(0), s7_wv_r);

  data_t s8_nt_r, s8_wn_r, s8_uvr_r;
  logic  s8_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_nt_r  <= nt_c.val;
      s8_wn_r  <= wn_c.val;
      s8_uvr_r <= s7_uvr_r;
      s8_sat_r <= s7_sat_r | nt_c.sat | wn_c.sat;
    end
  end

  // Stage 9 onward: f and w wait for the quotient.
  sres_t f_c;
  assign f_c = ap_rhs_pkg::sat_sub(s8_nt_r, s8_uvr_r);

  side_t side_r [0:SIDE_LAST];
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{sat: s8_sat_r | f_c.sat, f: f_c.val, w: s8_wn_r};
      for (int i = 1; i <= SIDE_LAST; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Restoring divider, DIV_STEP quotient bits per stage.
  function automatic dv_t div_step(dv_t x);
    dv_t y;
    logic [DW:0] r2;
    y = x;
    for (int b = 0; b < ap_rhs_pkg::DIV_STEP; b++) begin
      r2 = {y.rem, y.nq[NW-1]};
      y.nq = {y.nq[NW-2:0], 1'b0};
      if (r2 >= {1'b0, y.md}) begin
        r2 = r2 - {1'b0, y.md};
        y.nq[0] = 1'b1;
      end
      y.rem = r2[DW-1:0];
    end
    return y;
  endfunction

  dv_t dv_r [0:DS];
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_init;
      for (int j = 1; j <= DS; j++) begin
        dv_r[j] <= div_step(dv_r[j-1]);
      end
    end
  end

  // Quotient clip, or the zero-divisor result.
  sres_t qc_c;
  assign qc_c = ap_rhs_pkg::clip_quot(dv_r[DS].nq, dv_r[DS].neg);

  data_t q_r;
  logic  q_fault_r, q_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q_fault_r <= dv_r[DS].zero;
      if (dv_r[DS].zero) begin
        q_r     <= dv_r[DS].vpos ? ap_rhs_pkg::VMAX :
                   (dv_r[DS].vneg ? ap_rhs_pkg::VMIN : data_t'(0));
        q_sat_r <= 1'b0;
      end else begin
        q_r     <= qc_c.val;
        q_sat_r <= qc_c.sat;
      end
    end
  end

  prod_t pmq_r;
  logic  pmq_fault_r, pmq_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pmq_r       <= mu1_r * q_r;
      pmq_fault_r <= q_fault_r;
      pmq_sat_r   <= q_sat_r;
    end
  end

  sres_t mq_c, e_c;
  assign mq_c = ap_rhs_pkg::fx_round(pmq_r);
  assign e_c  = ap_rhs_pkg::sat_add(eps0_r, mq_c.val);

  data_t e_r;
  logic  e_fault_r, e_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      e_r       <= e_c.val;
      e_fault_r <= pmq_fault_r;
      e_sat_r   <= pmq_sat_r | mq_c.sat | e_c.sat;
    end
  end

  prod_t pew_r;
  data_t g_f_r;
  logic  g_fault_r, g_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pew_r     <= e_r * side_r[SIDE_LAST].w;
      g_f_r     <= side_r[SIDE_LAST].f;
      g_fault_r <= e_fault_r;
      g_sat_r   <= e_sat_r | side_r[SIDE_LAST].sat;
    end
  end

  // Output register
  sres_t g_c;
  assign g_c = ap_rhs_pkg::fx_round(pew_r);

  data_t out_u_r, out_v_r;
  logic  out_fault_r, out_sat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_u_r     <= g_f_r;
      out_v_r     <= g_c.val;
      out_fault_r <= g_fault_r;
      out_sat_r   <= g_sat_r | g_c.sat;
    end
  end

  assign out_ch.valid        = vld_r[NSTAGE];
  assign out_ch.rate_u       = out_u_r;
  assign out_ch.rate_v       = out_v_r;
  assign out_ch.divide_fault = out_fault_r;
  assign out_ch.saturated    = out_sat_r;

endmodule
